@@ rtl/extent_list_coalescer_macros.svh @@
// ----------------------------------------------------------------------------
// Extent list coalescer assertion macros
// Concurrent checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef EXTENT_LIST_COALESCER_MACROS_SVH
`define EXTENT_LIST_COALESCER_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ELC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must be followed by a property on the next edge.
`define ELC_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`else

`define ELC_ASSERT(lbl, prop, msg)
`define ELC_ASSERT_NEXT(lbl, cond, prop, msg)

`endif

`endif

@@ rtl/elc_pkg.sv @@
// ----------------------------------------------------------------------------
// Extent list coalescer package
// Table size, derived widths, operation and status codes, entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package elc_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W       = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);

    localparam int ADDR_W      = 64;
    localparam int TAG_W       = 32;
    localparam int ENTRY_IDX_W = 6;
    localparam int COUNT_OUT_W = 7;

    typedef logic [1:0] op_t;
    localparam op_t OP_APPEND = 2'd0;
    localparam op_t OP_TRUNC  = 2'd1;
    localparam op_t OP_READ   = 2'd2;
    localparam op_t OP_CLEAR  = 2'd3;

    typedef logic [2:0] status_t;
    localparam status_t ST_NEW     = 3'd0;
    localparam status_t ST_MERGED  = 3'd1;
    localparam status_t ST_FULL    = 3'd2;
    localparam status_t ST_TRUNC   = 3'd3;
    localparam status_t ST_NOCUT   = 3'd4;
    localparam status_t ST_READ    = 3'd5;
    localparam status_t ST_BADIDX  = 3'd6;
    localparam status_t ST_CLEARED = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [TAG_W-1:0]  tag;
    } entry_t;

endpackage

`default_nettype wire

@@ rtl/elc_if.sv @@
// ----------------------------------------------------------------------------
// Extent list coalescer channels
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface elc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] offset;
    logic [63:0] block_size;
    logic [31:0] tag;
    logic [63:0] size_limit;
    logic [5:0]  entry_index;

    modport source (output valid, operation, offset, block_size, tag, size_limit,
                    entry_index, input ready);
    modport sink   (input valid, operation, offset, block_size, tag, size_limit,
                    entry_index, output ready);
endinterface

interface elc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] entry_start;
    logic [63:0] entry_end;
    logic [31:0] entry_tag;
    logic [6:0]  entry_count;

    modport source (output valid, status, entry_start, entry_end, entry_tag,
                    entry_count, input ready);
    modport sink   (input valid, status, entry_start, entry_end, entry_tag,
                    entry_count, output ready);
endinterface

`default_nettype wire

@@ rtl/extent_list_coalescer.sv @@
// ----------------------------------------------------------------------------
// Extent list coalescer
// Ordered extent table in one synchronous RAM with append/merge, truncate,
// read and clear operations; one response transaction per request.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake     | Payload
//  --------+-----+---------------+---------------------------------------------
//  req     | in  | valid / ready | operation, offset, block_size, tag,
//          |     |               | size_limit, entry_index
//  rsp     | out | valid / ready | status, entry_start, entry_end, entry_tag,
//          |     |               | entry_count
//
//  Steps: clear IDLE, DONE; append IDLE, APPEND, DONE; read IDLE (RAM read),
//  READ, DONE; truncate IDLE, TR_LEN and TR_SUM per walked entry, TR_CUT when
//  a cut is made, DONE. The walk over the single read port sets the worst case.
//  One request is in flight at a time; req.ready is high only in IDLE.
//  A finished response sits in the output register, so the next request is
//  taken while the previous response is still stalled on rsp.ready.
//  Reset clears the count and the control state; the RAM is not cleared,
//  entries at or above the count are never read back.
// ----------------------------------------------------------------------------
`default_nettype none

module extent_list_coalescer (
    input  wire logic clk,
    input  wire logic rst_n,
    elc_req_if.sink   req,
    elc_rsp_if.source rsp
);
    import elc_pkg::*;

`include "extent_list_coalescer_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_READ,
        S_TR_LEN,
        S_TR_SUM,
        S_TR_CUT,
        S_DONE
    } state_t;

    // Extent table RAM
    entry_t ext_mem [MAX_EXTENTS];
    entry_t rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    // Control and datapath registers
    state_t            state_reg,  state_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [IDX_W-1:0]  walk_reg,   walk_next;
    logic [ADDR_W-1:0] sum_reg,    sum_next;
    logic [ADDR_W-1:0] len_reg,    len_next;
    entry_t            cur_reg,    cur_next;
    entry_t            last_reg,   last_next;   // copy of the tail entry

    logic [ADDR_W-1:0]      off_reg,   off_next;
    logic [ADDR_W-1:0]      bsize_reg, bsize_next;
    logic [TAG_W-1:0]       tag_reg,   tag_next;
    logic [ADDR_W-1:0]      limit_reg, limit_next;
    logic [ENTRY_IDX_W-1:0] idx_reg,   idx_next;

    status_t res_status_reg, res_status_next;
    entry_t  res_entry_reg,  res_entry_next;

    logic                   out_valid_reg,  out_valid_next;
    status_t                out_status_reg, out_status_next;
    entry_t                 out_entry_reg,  out_entry_next;
    logic [COUNT_OUT_W-1:0] out_count_reg,  out_count_next;

    // Combinational helpers
    logic [CNT_W-1:0]  last_pos;
    logic [CNT_W-1:0]  walk_plus1;
    logic [ADDR_W-1:0] app_end;
    logic              app_merge;
    logic [ADDR_W:0]   sum_wide;
    logic [ADDR_W-1:0] sum_sat;
    logic [ADDR_W-1:0] cut_end;

    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_start = out_entry_reg.start_addr;
    assign rsp.entry_end   = out_entry_reg.end_addr;
    assign rsp.entry_tag   = out_entry_reg.tag;
    assign rsp.entry_count = out_count_reg;

    assign last_pos   = count_reg - CNT_W'(1);
    assign walk_plus1 = CNT_W'(walk_reg) + CNT_W'(1);

    // append: new end wraps modulo 2^64; merge only onto a contiguous tail
    assign app_end   = off_reg + bsize_reg - ADDR_W'(1);
    assign app_merge = (count_reg != '0) && (last_reg.end_addr + ADDR_W'(1) == off_reg)
                       && (last_reg.tag == tag_reg);

    // truncate: saturating running sum, then trim by the excess
    assign sum_wide = {1'b0, sum_reg} + {1'b0, len_reg};
    assign sum_sat  = sum_wide[ADDR_W] ? {ADDR_W{1'b1}} : sum_wide[ADDR_W-1:0];
    assign cut_end  = cur_reg.end_addr - sum_reg + limit_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        walk_next       = walk_reg;
        sum_next        = sum_reg;
        len_next        = len_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        off_next        = off_reg;
        bsize_next      = bsize_reg;
        tag_next        = tag_reg;
        limit_next      = limit_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    off_next   = req.offset;
                    bsize_next = req.block_size;
                    tag_next   = req.tag;
                    limit_next = req.size_limit;
                    idx_next   = req.entry_index;
                    case (op_t'(req.operation))
                        OP_APPEND:
                        begin
                            state_next = S_APPEND;
                        end
                        OP_READ:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = IDX_W'(req.entry_index);
                            state_next = S_READ;
                        end
                        OP_TRUNC:
                        begin
                            sum_next  = '0;
                            walk_next = '0;
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_NOCUT;
                                res_entry_next  = '0;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                state_next = S_TR_LEN;
                            end
                        end
                        default:
                        begin
                            count_next      = '0;
                            res_status_next = ST_CLEARED;
                            res_entry_next  = '0;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_APPEND:
            begin
                if (app_merge)
                begin
                    mem_we             = 1'b1;
                    mem_waddr          = last_pos[IDX_W-1:0];
                    mem_wdata          = last_reg;
                    mem_wdata.end_addr = app_end;
                    last_next          = mem_wdata;
                    res_status_next    = ST_MERGED;
                    res_entry_next     = mem_wdata;
                end
                else if (32'(count_reg) >= MAX_EXTENTS)
                begin
                    res_status_next = ST_FULL;
                    res_entry_next  = '0;
                end
                else
                begin
                    mem_we                = 1'b1;
                    mem_waddr             = count_reg[IDX_W-1:0];
                    mem_wdata.start_addr  = off_reg;
                    mem_wdata.end_addr    = app_end;
                    mem_wdata.tag         = tag_reg;
                    last_next             = mem_wdata;
                    count_next            = count_reg + CNT_W'(1);
                    res_status_next       = ST_NEW;
                    res_entry_next        = mem_wdata;
                end
                state_next = S_DONE;
            end

            S_READ:
            begin
                if (32'(idx_reg) < 32'(count_reg))
                begin
                    res_status_next = ST_READ;
                    res_entry_next  = rd_data_reg;
                end
                else
                begin
                    res_status_next = ST_BADIDX;
                    res_entry_next  = '0;
                end
                state_next = S_DONE;
            end

            S_TR_LEN:
            begin
                cur_next   = rd_data_reg;
                len_next   = rd_data_reg.end_addr - rd_data_reg.start_addr + ADDR_W'(1);
                state_next = S_TR_SUM;
            end

            S_TR_SUM:
            begin
                if ((cur_reg.tag != '0) && (sum_sat >= limit_reg))
                begin
                    sum_next   = sum_sat;
                    state_next = S_TR_CUT;
                end
                else
                begin
                    if (cur_reg.tag != '0)
                    begin
                        sum_next = sum_sat;
                    end
                    if (walk_plus1 == count_reg)
                    begin
                        res_status_next = ST_NOCUT;
                        res_entry_next  = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        walk_next  = walk_plus1[IDX_W-1:0];
                        mem_re     = 1'b1;
                        mem_raddr  = walk_plus1[IDX_W-1:0];
                        state_next = S_TR_LEN;
                    end
                end
            end

            S_TR_CUT:
            begin
                mem_we             = 1'b1;
                mem_waddr          = walk_reg;
                mem_wdata          = cur_reg;
                mem_wdata.end_addr = cut_end;
                last_next          = mem_wdata;
                count_next         = walk_plus1;
                res_status_next    = ST_TRUNC;
                res_entry_next     = mem_wdata;
                state_next         = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_entry_next  = res_entry_reg;
                    out_count_next  = COUNT_OUT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            walk_reg       <= '0;
            sum_reg        <= '0;
            len_reg        <= '0;
            cur_reg        <= '0;
            last_reg       <= '0;
            off_reg        <= '0;
            bsize_reg      <= '0;
            tag_reg        <= '0;
            limit_reg      <= '0;
            idx_reg        <= '0;
            res_status_reg <= ST_NEW;
            res_entry_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_NEW;
            out_entry_reg  <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            walk_reg       <= walk_next;
            sum_reg        <= sum_next;
            len_reg        <= len_next;
            cur_reg        <= cur_next;
            last_reg       <= last_next;
            off_reg        <= off_next;
            bsize_reg      <= bsize_next;
            tag_reg        <= tag_next;
            limit_reg      <= limit_next;
            idx_reg        <= idx_next;
            res_status_reg <= res_status_next;
            res_entry_reg  <= res_entry_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_entry_reg  <= out_entry_next;
            out_count_reg  <= out_count_next;
        end
    end

    // Table RAM: one write, one registered read. Writes and reads of the
    // same entry never overlap since the sequencer handles one request.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ext_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= ext_mem[mem_raddr];
        end
    end

    `ELC_ASSERT(a_count_bound, 32'(count_reg) <= MAX_EXTENTS, "extent count above table size")
    `ELC_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_reg != S_IDLE, "request accepted but sequencer stayed idle")
    `ELC_ASSERT(a_write_src, !mem_we || state_reg == S_APPEND || state_reg == S_TR_CUT, "table write outside append or cut")
    `ELC_ASSERT(a_walk_range, state_reg != S_TR_LEN || 32'(walk_reg) < 32'(count_reg), "truncate walk past table tail")

endmodule

`default_nettype wire

@@ verif/extent_list_coalescer_test.sv @@
// ----------------------------------------------------------------------------
// Extent list coalescer testbench
// Drives append, truncate, read and clear transactions through the request
// channel and checks every response transaction field by field against a
// shadow extent table kept in the bench. A short table of directed requests
// comes first (wrapping ends, zero and full-range block sizes, a saturating
// truncate sum, bad indexes), then random mixes of coalescing streams, table
// fills up to full, and noise, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module extent_list_coalescer_test;

    import elc_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_MAX     = '1;
    localparam logic [TAG_W-1:0]  TAG_MAX      = '1;
    localparam int                RANDOM_ITEMS = 400;
    localparam int                TABLE_ROWS   = 23;
    // Worst case is a truncate walking the whole table.
    localparam int                SETTLE_CYCLES = 2 * MAX_EXTENTS + 8;

    typedef struct packed {
        op_t                    op;
        logic [ADDR_W-1:0]      offset;
        logic [ADDR_W-1:0]      block_size;
        logic [TAG_W-1:0]       tag;
        logic [ADDR_W-1:0]      size_limit;
        logic [ENTRY_IDX_W-1:0] entry_index;
    } extent_req_t;

    typedef struct packed {
        status_t                status;
        entry_t                 ext;
        logic [COUNT_OUT_W-1:0] count;
    } extent_reply_t;

    // One directed row: the request, and a typed-in reply where it is obvious.
    typedef struct {
        extent_req_t   rq;
        bit            typed;
        extent_reply_t reply;
    } directed_row_t;

    typedef enum int { MIX_STREAM, MIX_FILL, MIX_NOISE, MIX_PAUSE } stim_mix_t;
    typedef enum int { DRAIN_FREE, DRAIN_COIN, DRAIN_PERIODIC, DRAIN_SPARSE } drain_mode_t;

    logic clk;
    logic rst_n;

    elc_req_if req_ch ();
    elc_rsp_if rsp_ch ();

    extent_list_coalescer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // Shadow extent table and the queue of replies still owed by the block
    // ------------------------------------------------------------------------
    entry_t        shadow_table [MAX_EXTENTS];
    int unsigned   shadow_count = 0;
    // Entries below this mark have been written at least once; reads never
    // go above it so the block's RAM is only ever read where it holds data.
    int unsigned   high_water = 0;
    extent_reply_t expected_replies [$];

    int            mismatch_count = 0;
    int unsigned   requests_sent = 0;
    int unsigned   burst_left = 0;

    // Directed requests. Typed replies only where they read straight off the
    // table state; the rest go through the shadow table.
    directed_row_t directed_requests [TABLE_ROWS] = '{
        // truncate and clear on the empty table
        '{'{OP_TRUNC, 64'd0, 64'd0, 32'd0, 64'd0, 6'd0}, 1'b1, '{ST_NOCUT, '0, 7'd0}},
        '{'{OP_CLEAR, 64'd0, 64'd0, 32'd0, 64'd0, 6'd0}, 1'b1, '{ST_CLEARED, '0, 7'd0}},
        // tag-zero extent, then a contiguous merge into it
        '{'{OP_APPEND, 64'd0, 64'd1, 32'd0, 64'd0, 6'd0}, 1'b1,
          '{ST_NEW, '{64'd0, 64'd0, 32'd0}, 7'd1}},
        '{'{OP_APPEND, 64'd1, 64'd16, 32'd0, 64'd0, 6'd0}, 1'b1,
          '{ST_MERGED, '{64'd0, 64'd16, 32'd0}, 7'd1}},
        // contiguous but with another tag: new entry
        '{'{OP_APPEND, 64'd17, 64'd4, 32'd7, 64'd0, 6'd0}, 1'b1,
          '{ST_NEW, '{64'd17, 64'd20, 32'd7}, 7'd2}},
        // full-range block wraps its end below its start
        '{'{OP_APPEND, 64'd100, ADDR_MAX, TAG_MAX, 64'd0, 6'd0}, 1'b0, '0},
        // zero-size block merges and leaves the end where it was
        '{'{OP_APPEND, 64'd99, 64'd0, TAG_MAX, 64'd0, 6'd0}, 1'b0, '0},
        '{'{OP_APPEND, 64'd0, ADDR_MAX, 32'd1, 64'd0, 6'd0}, 1'b0, '0},
        // grow to the top of the address space, then merge across the wrap
        '{'{OP_APPEND, ADDR_MAX, 64'd1, 32'd1, 64'd0, 6'd0}, 1'b0, '0},
        '{'{OP_APPEND, 64'd0, 64'd5, 32'd1, 64'd0, 6'd0}, 1'b0, '0},
        '{'{OP_READ, 64'd0, 64'd0, 32'd0, 64'd0, 6'd0}, 1'b1,
          '{ST_READ, '{64'd0, 64'd16, 32'd0}, 7'd4}},
        '{'{OP_READ, 64'd0, 64'd0, 32'd0, 64'd0, 6'd2}, 1'b0, '0},
        // sum saturates on the full-range extent and meets the largest limit
        '{'{OP_TRUNC, 64'd0, 64'd0, 32'd0, ADDR_MAX, 6'd0}, 1'b0, '0},
        // zero limit trims the first data extent down to nothing
        '{'{OP_TRUNC, 64'd0, 64'd0, 32'd0, 64'd0, 6'd0}, 1'b0, '0},
        '{'{OP_TRUNC, 64'd0, 64'd0, 32'd0, 64'd1, 6'd0}, 1'b1, '{ST_NOCUT, '0, 7'd2}},
        // index past the count but on an entry written earlier
        '{'{OP_READ, 64'd0, 64'd0, 32'd0, 64'd0, 6'd3}, 1'b1, '{ST_BADIDX, '0, 7'd2}},
        '{'{OP_READ, 64'd0, 64'd0, 32'd0, 64'd0, 6'd1}, 1'b0, '0},
        '{'{OP_CLEAR, 64'd0, 64'd0, 32'd0, 64'd0, 6'd0}, 1'b1, '{ST_CLEARED, '0, 7'd0}},
        '{'{OP_READ, 64'd0, 64'd0, 32'd0, 64'd0, 6'd0}, 1'b1, '{ST_BADIDX, '0, 7'd0}},
        '{'{OP_APPEND, ADDR_MAX, 64'd1, 32'd0, 64'd0, 6'd0}, 1'b0, '0},
        '{'{OP_APPEND, 64'd0, 64'd1, 32'd0, 64'd0, 6'd0}, 1'b0, '0},
        // only tag-zero extents: nothing counts toward the limit
        '{'{OP_TRUNC, 64'd0, 64'd0, 32'd0, 64'd0, 6'd0}, 1'b1, '{ST_NOCUT, '0, 7'd1}},
        '{'{OP_CLEAR, 64'd0, 64'd0, 32'd0, 64'd0, 6'd0}, 1'b1, '{ST_CLEARED, '0, 7'd0}}
    };

    // ------------------------------------------------------------------------
    // Shadow table update: applies one accepted request, returns its reply
    // ------------------------------------------------------------------------
    function automatic extent_reply_t predict_extent_reply(input extent_req_t rq);
        extent_reply_t     r;
        logic [ADDR_W-1:0] new_end;
        logic [ADDR_W-1:0] sum;
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] grown;
        int unsigned       last;
        int unsigned       i;
        r = '0;
        case (rq.op)
            OP_APPEND:
            begin
                new_end = rq.offset + rq.block_size - 64'd1;
                last = (shadow_count == 0) ? 0 : shadow_count - 1;
                if (shadow_count != 0 && shadow_table[last].end_addr + 64'd1 == rq.offset &&
                    shadow_table[last].tag == rq.tag)
                begin
                    // merge needs no free slot, so it also works on a full table
                    shadow_table[last].end_addr = new_end;
                    r.status = ST_MERGED;
                    r.ext = shadow_table[last];
                end
                else if (shadow_count >= MAX_EXTENTS)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    shadow_table[shadow_count] = '{rq.offset, new_end, rq.tag};
                    r.status = ST_NEW;
                    r.ext = shadow_table[shadow_count];
                    shadow_count++;
                    if (shadow_count > high_water)
                    begin
                        high_water = shadow_count;
                    end
                end
            end
            OP_TRUNC:
            begin
                r.status = ST_NOCUT;
                sum = '0;
                // a cut shrinks shadow_count to i + 1, which ends the walk
                for (i = 0; i < shadow_count; i++)
                begin
                    if (shadow_table[i].tag != '0)
                    begin
                        len = shadow_table[i].end_addr - shadow_table[i].start_addr + 64'd1;
                        grown = sum + len;
                        sum = (grown < sum) ? ADDR_MAX : grown;
                        if (sum >= rq.size_limit)
                        begin
                            shadow_table[i].end_addr -= sum - rq.size_limit;
                            shadow_count = i + 1;
                            r.status = ST_TRUNC;
                            r.ext = shadow_table[i];
                        end
                    end
                end
            end
            OP_READ:
            begin
                if (rq.entry_index < shadow_count)
                begin
                    r.status = ST_READ;
                    r.ext = shadow_table[rq.entry_index];
                end
                else
                begin
                    r.status = ST_BADIDX;
                end
            end
            OP_CLEAR:
            begin
                shadow_count = 0;
                r.status = ST_CLEARED;
            end
        endcase
        r.count = COUNT_OUT_W'(shadow_count);
        return r;
    endfunction

    // Saturating sum of data-bearing lengths, used to aim truncate limits.
    function automatic logic [ADDR_W-1:0] data_total();
        logic [ADDR_W-1:0] sum;
        logic [ADDR_W-1:0] grown;
        sum = '0;
        for (int unsigned i = 0; i < shadow_count; i++)
        begin
            if (shadow_table[i].tag != '0)
            begin
                grown = sum + (shadow_table[i].end_addr - shadow_table[i].start_addr + 64'd1);
                sum = (grown < sum) ? ADDR_MAX : grown;
            end
        end
        return sum;
    endfunction

    // ------------------------------------------------------------------------
    // Random field pickers
    // ------------------------------------------------------------------------
    function automatic logic [ADDR_W-1:0] random_addr();
        return {$urandom, $urandom};
    endfunction

    // All fields random; the scenario then overrides what matters.
    function automatic extent_req_t random_payload();
        extent_req_t rq;
        rq.op = op_t'($urandom_range(0, 3));
        rq.offset = random_addr();
        rq.block_size = random_addr();
        rq.tag = $urandom;
        rq.size_limit = random_addr();
        rq.entry_index = ENTRY_IDX_W'($urandom_range(0, 63));
        return rq;
    endfunction

    // Mostly small blocks, with the odd zero, full-range or arbitrary size.
    function automatic logic [ADDR_W-1:0] pick_block_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ADDR_MAX;
            2: return random_addr();
            3, 4, 5: return ADDR_W'($urandom_range(1, 16));
            default: return ADDR_W'($urandom_range(1, 4096));
        endcase
    endfunction

    // A small tag alphabet so equal tags, and tag zero, come up often.
    function automatic logic [TAG_W-1:0] pick_tag();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return 32'd1;
            2: return $urandom_range(2, 5);
            default: return $urandom;
        endcase
    endfunction

    // Valid index most of the time; otherwise past the count on an entry written
    // before when there is one, else any written entry (index 0 while none is).
    function automatic logic [ENTRY_IDX_W-1:0] pick_read_index();
        if (shadow_count != 0 && $urandom_range(0, 4) != 0)
        begin
            return ENTRY_IDX_W'($urandom_range(0, shadow_count - 1));
        end
        if (high_water > shadow_count)
        begin
            return ENTRY_IDX_W'($urandom_range(shadow_count, high_water - 1));
        end
        return (high_water == 0) ? '0 : ENTRY_IDX_W'($urandom_range(0, high_water - 1));
    endfunction

    // Limits aimed around the data held so cuts land inside the table.
    function automatic logic [ADDR_W-1:0] pick_limit();
        logic [ADDR_W-1:0] total;
        logic [ADDR_W-1:0] delta;
        total = data_total();
        delta = ADDR_W'($urandom_range(0, 4095));
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ADDR_MAX;
            2: return random_addr();
            3: return total;
            4: return total + ADDR_W'($urandom_range(1, 50));
            default: return (total > delta) ? total - delta : '0;
        endcase
    endfunction

    function automatic stim_mix_t pick_mix();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 13)
        begin
            return MIX_STREAM;
        end
        if (roll < 15)
        begin
            return MIX_FILL;
        end
        if (roll < 18)
        begin
            return MIX_NOISE;
        end
        return MIX_PAUSE;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: bursts with random gaps; inputs move on the falling
    // edge, acceptance is seen on the rising edge. Entered and left at a
    // falling edge.
    // ------------------------------------------------------------------------
    task automatic send_request(input extent_req_t rq, input bit use_typed,
                                input extent_reply_t typed_reply);
        int unsigned   gap;
        extent_reply_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                req_ch.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_ch.operation = rq.op;
        req_ch.offset = rq.offset;
        req_ch.block_size = rq.block_size;
        req_ch.tag = rq.tag;
        req_ch.size_limit = rq.size_limit;
        req_ch.entry_index = rq.entry_index;
        req_ch.valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        // the shadow table moves on every accepted request, typed or not
        predicted = predict_extent_reply(rq);
        expected_replies.push_back(use_typed ? typed_reply : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_random(input extent_req_t rq);
        send_request(rq, 1'b0, '0);
    endtask

    // Hold off new requests until every owed response has come back.
    task automatic drain_replies();
        req_ch.valid = 1'b0;
        while (expected_replies.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Scenarios
    // ------------------------------------------------------------------------
    // Mostly appends, often continuing the last extent, mixed with reads,
    // truncates and the occasional clear.
    task automatic run_stream();
        extent_req_t rq;
        int unsigned n;
        int unsigned pick;
        int unsigned last;
        n = $urandom_range(4, 20);
        if ($urandom_range(0, 3) == 0)
        begin
            rq = random_payload();
            rq.op = OP_CLEAR;
            send_random(rq);
        end
        repeat (n)
        begin
            rq = random_payload();
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                rq.op = OP_APPEND;
                rq.block_size = pick_block_size();
                rq.tag = pick_tag();
                if (shadow_count != 0 && $urandom_range(0, 9) < 6)
                begin
                    last = shadow_count - 1;
                    rq.offset = shadow_table[last].end_addr + 64'd1;
                    if ($urandom_range(0, 4) != 0)
                    begin
                        rq.tag = shadow_table[last].tag;
                    end
                end
            end
            else if (pick < 78)
            begin
                rq.op = OP_READ;
                rq.entry_index = pick_read_index();
            end
            else if (pick < 96)
            begin
                rq.op = OP_TRUNC;
                rq.size_limit = pick_limit();
            end
            else
            begin
                rq.op = OP_CLEAR;
            end
            send_random(rq);
        end
    endtask

    // Fill the table to full, bounce a few appends off it, merge into the
    // last slot, read the top entry and cut somewhere.
    task automatic run_fill();
        extent_req_t rq;
        if ($urandom_range(0, 1) == 0)
        begin
            rq = random_payload();
            rq.op = OP_CLEAR;
            send_random(rq);
        end
        while (shadow_count < MAX_EXTENTS)
        begin
            rq = random_payload();
            rq.op = OP_APPEND;
            rq.block_size = ($urandom_range(0, 7) == 0) ? pick_block_size()
                                                        : ADDR_W'($urandom_range(1, 64));
            send_random(rq);
        end
        repeat ($urandom_range(2, 4))
        begin
            rq = random_payload();
            rq.op = OP_APPEND;
            send_random(rq);
        end
        rq = random_payload();
        rq.op = OP_APPEND;
        rq.offset = shadow_table[MAX_EXTENTS-1].end_addr + 64'd1;
        rq.tag = shadow_table[MAX_EXTENTS-1].tag;
        rq.block_size = pick_block_size();
        send_random(rq);
        rq = random_payload();
        rq.op = OP_READ;
        rq.entry_index = ENTRY_IDX_W'(MAX_EXTENTS - 1);
        send_random(rq);
        rq = random_payload();
        rq.op = OP_TRUNC;
        rq.size_limit = pick_limit();
        send_random(rq);
    endtask

    // Arbitrary operations and fields; reads still stay on written entries.
    task automatic run_noise();
        extent_req_t rq;
        repeat ($urandom_range(3, 8))
        begin
            rq = random_payload();
            if (rq.op == OP_READ)
            begin
                rq.entry_index = pick_read_index();
            end
            send_random(rq);
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock, timeout, receiver
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver ready follows a mode redrawn after each span of random length:
    // always ready, coin flips, periodic stall runs, or rare stalls.
    initial
    begin
        drain_mode_t mode;
        int unsigned span;
        rsp_ch.ready = 1'b0;
        forever
        begin
            mode = drain_mode_t'($urandom_range(0, 3));
            span = $urandom_range(16, 96);
            for (int unsigned k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    DRAIN_FREE:     rsp_ch.ready = 1'b1;
                    DRAIN_COIN:     rsp_ch.ready = 1'($urandom_range(0, 1));
                    DRAIN_PERIODIC: rsp_ch.ready = (k % 11) >= 7;
                    default:        rsp_ch.ready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response checker
    // ------------------------------------------------------------------------
    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        extent_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected response transaction, expected none, actual status %0d",
                         $time, rsp_ch.status);
                mismatch_count++;
            end
            else
            begin
                want = expected_replies.pop_front();
                check_field("status", 64'(want.status), 64'(rsp_ch.status));
                check_field("entry_start", want.ext.start_addr, rsp_ch.entry_start);
                check_field("entry_end", want.ext.end_addr, rsp_ch.entry_end);
                check_field("entry_tag", 64'(want.ext.tag), 64'(rsp_ch.entry_tag));
                check_field("entry_count", 64'(want.count), 64'(rsp_ch.entry_count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bit first_mix;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_APPEND;
        req_ch.offset = '0;
        req_ch.block_size = '0;
        req_ch.tag = '0;
        req_ch.size_limit = '0;
        req_ch.entry_index = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_requests[n])
        begin
            send_request(directed_requests[n].rq, directed_requests[n].typed,
                         directed_requests[n].reply);
        end
        // sender waits here for the block to go fully quiet at least once
        drain_replies();

        // first mix is always a fill so the full-table path is covered
        first_mix = 1'b1;
        while (requests_sent < TABLE_ROWS + RANDOM_ITEMS)
        begin
            case (first_mix ? MIX_FILL : pick_mix())
                MIX_STREAM: run_stream();
                MIX_FILL:   run_fill();
                MIX_NOISE:  run_noise();
                default:    drain_replies();
            endcase
            first_mix = 1'b0;
        end

        req_ch.valid = 1'b0;
        while (expected_replies.size() != 0)
        begin
            @(posedge clk);
        end
        // catch any stray response transaction after the last one owed
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
